FILE: rtl/sm3h_pkg.sv
`timescale 1ns / 1ps
package sm3h_pkg;

	localparam int BLOCK_BITS = 512;
	localparam int WORD_BITS = 32;
	localparam int BLOCK_WORDS = BLOCK_BITS / WORD_BITS;
	localparam int BLOCK_BYTES = BLOCK_BITS / 8;
	localparam int ROUNDS = 64;
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [31:0] T_LOW = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] SM3_IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	// One block handed from the front end to the compression core.
	typedef struct packed {
		logic [BLOCK_BITS-1:0] block;
		logic                  last_blk;
	} job_t;

	typedef enum logic [1:0] {
		FR_TAKE,
		FR_PAD,
		FR_LEN
	} fr_state_t;

	typedef enum logic [1:0] {
		CO_IDLE,
		CO_ROUND,
		CO_EMIT
	} co_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

FILE: rtl/sm3h_if.sv
`timescale 1ns / 1ps
interface sm3h_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface sm3h_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

FILE: rtl/sm3h_front.sv
`timescale 1ns / 1ps
module sm3h_front (
	input  logic           clk,
	input  logic           arst_n,
	sm3h_msg_if.sink       msg,
	output logic           push_valid,
	input  logic           push_ready,
	output sm3h_pkg::job_t push_job
);
	import sm3h_pkg::*;

	fr_state_t             state_q, state_d;
	logic [BLOCK_BITS-1:0] blk_q, blk_d;
	logic [5:0]            cnt_q, cnt_d;
	logic [54:0]           bcnt_q, bcnt_d;
	logic [BLOCK_BITS-1:0] buf_wr, pad_blk, len_blk;
	logic [63:0]           bit_len;
	logic                  fits_len;
	logic                  acc;

	assign bit_len  = {bcnt_q, cnt_q, 3'b000};
	assign fits_len = (cnt_q <= 6'd55);
	assign len_blk  = {{(BLOCK_BITS-64){1'b0}}, bit_len};

	always_comb begin
		buf_wr  = blk_q;
		pad_blk = blk_q;
		for (int k = 0; k < BLOCK_BYTES; k++) begin
			if (6'(k) == cnt_q) begin
				buf_wr[BLOCK_BITS-1-8*k -: 8]  = msg.data_byte;
				pad_blk[BLOCK_BITS-1-8*k -: 8] = PAD_BYTE;
			end else if (6'(k) > cnt_q) begin
				pad_blk[BLOCK_BITS-1-8*k -: 8] = 8'h00;
			end
		end
		if (fits_len) begin
			pad_blk[63:0] = bit_len;
		end
	end

	always_comb begin
		state_d    = state_q;
		blk_d      = blk_q;
		cnt_d      = cnt_q;
		bcnt_d     = bcnt_q;
		push_valid = 1'b0;
		push_job   = '{block: buf_wr, last_blk: 1'b0};
		msg.ready  = 1'b0;
		acc        = 1'b0;
		unique case (state_q)
			FR_TAKE: begin
				msg.ready = push_ready;
				acc       = msg.valid && push_ready;
				if (acc) begin
					if (msg.byte_present) begin
						blk_d = buf_wr;
						cnt_d = cnt_q + 6'd1;
						if (cnt_q == 6'd63) begin
							push_valid = 1'b1;
							bcnt_d     = bcnt_q + 55'd1;
						end
					end
					if (msg.end_of_message) begin
						state_d = FR_PAD;
					end
				end
			end
			FR_PAD: begin
				push_valid = 1'b1;
				push_job   = '{block: pad_blk, last_blk: fits_len};
				if (push_ready) begin
					if (fits_len) begin
						cnt_d   = '0;
						bcnt_d  = '0;
						state_d = FR_TAKE;
					end else begin
						state_d = FR_LEN;
					end
				end
			end
			FR_LEN: begin
				push_valid = 1'b1;
				push_job   = '{block: len_blk, last_blk: 1'b1};
				if (push_ready) begin
					cnt_d   = '0;
					bcnt_d  = '0;
					state_d = FR_TAKE;
				end
			end
			default: begin
				state_d = FR_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_TAKE;
			cnt_q   <= '0;
			bcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bcnt_q  <= bcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		blk_q <= blk_d;
	end
endmodule

FILE: rtl/sm3h_queue.sv
`timescale 1ns / 1ps
module sm3h_queue #(
	parameter int DEPTH = sm3h_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sm3h_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sm3h_pkg::job_t pop_job
);
	import sm3h_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] fill_q;
	logic          do_push, do_pop;

	assign push_ready = (fill_q != CW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end
endmodule

FILE: rtl/sm3h_core.sv
`timescale 1ns / 1ps
module sm3h_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  sm3h_pkg::job_t pop_job,
	sm3h_dig_if.source     dig
);
	import sm3h_pkg::*;

	co_state_t   state_q, state_d;
	logic [31:0] cv_q [8];
	logic [31:0] r_q [8];
	logic [31:0] w_q [BLOCK_WORDS];
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        last_q;
	logic [31:0] nr [8];
	logic [31:0] w_new;
	logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2;
	logic        load, step, emit_go;

	// Expansion runs alongside the rounds over a sixteen-word window.
	assign w_new = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
		^ rotl(w_q[3], 5'd7) ^ w_q[10];

	always_comb begin
		tj  = (rnd_q < 6'd16) ? T_LOW : T_HIGH;
		a12 = rotl(r_q[0], 5'd12);
		ss1 = rotl(a12 + r_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1   = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2   = gg + r_q[7] + ss1 + w_q[0];
		nr[0] = tt1;
		nr[1] = r_q[0];
		nr[2] = rotl(r_q[1], 5'd9);
		nr[3] = r_q[2];
		nr[4] = perm0(tt2);
		nr[5] = r_q[4];
		nr[6] = rotl(r_q[5], 5'd19);
		nr[7] = r_q[6];
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		dig.valid = 1'b0;
		load      = 1'b0;
		step      = 1'b0;
		emit_go   = 1'b0;
		unique case (state_q)
			CO_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					load    = 1'b1;
					state_d = CO_ROUND;
				end
			end
			CO_ROUND: begin
				step = 1'b1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					state_d = last_q ? CO_EMIT : CO_IDLE;
				end
			end
			CO_EMIT: begin
				dig.valid = 1'b1;
				if (dig.ready) begin
					emit_go = 1'b1;
					if (idx_q == 3'd7) begin
						state_d = CO_IDLE;
					end
				end
			end
			default: begin
				state_d = CO_IDLE;
			end
		endcase
	end

	assign dig.digest_word = cv_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CO_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= SM3_IV[i];
			end
		end else begin
			state_q <= state_d;
			if (load) begin
				rnd_q  <= '0;
				idx_q  <= '0;
				last_q <= pop_job.last_blk;
			end
			if (step) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					for (int i = 0; i < 8; i++) begin
						cv_q[i] <= cv_q[i] ^ nr[i];
					end
				end
			end
			if (emit_go) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						cv_q[i] <= SM3_IV[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				w_q[i] <= pop_job.block[BLOCK_BITS-1-WORD_BITS*i -: WORD_BITS];
			end
			for (int i = 0; i < 8; i++) begin
				r_q[i] <= cv_q[i];
			end
		end else if (step) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_WORDS-1] <= w_new;
			for (int i = 0; i < 8; i++) begin
				r_q[i] <= nr[i];
			end
		end
	end
endmodule

FILE: rtl/sm3_hash_engine_unit.sv
`timescale 1ns / 1ps
// Channel   Role    Payload
// msg       sink    data_byte[7:0], byte_present, end_of_message
// dig       source  digest_word[31:0], word_index[2:0], last_word
//
// The front end packs each accepted message byte into the block buffer.
// The core processes each full or padded block with one load and then 64 rounds of the
// single round unit, with the message expansion done alongside in a word window.
// End of message costs one or two further blocks, then eight digest words.
// The block queue lets the front end keep taking bytes while the core works; the front
// end stalls while it hands over the padded blocks and while the queue is full.
module sm3_hash_engine_unit #(
	parameter int QUEUE_DEPTH = sm3h_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	sm3h_msg_if.sink   msg,
	sm3h_dig_if.source dig
);
	import sm3h_pkg::*;

	// Blocks travel from the front end through the queue to the core as one transaction each.
	logic push_valid, push_ready, pop_valid, pop_ready;
	job_t push_job, pop_job;

	sm3h_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	sm3h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// The core holds the chaining value and presents the digest once a final block ends.
	sm3h_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.dig       (dig)
	);
endmodule
